FILE: src/rch_pkg.sv
// ----------------------------------------------------------------------------
// rch_pkg
// Shared types and constants of the unit cylinder ray hit pipeline.
// ----------------------------------------------------------------------------
package rch_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CW           = 58;
  localparam int TURN_W       = 32;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic        [31:0] tl;
    logic               hp;
    logic        [31:0] pt;
  } ray_t;

  typedef struct packed {
    ray_t               ray;
    logic        [63:0] a;
    logic signed [64:0] b;
    logic               live;
  } sq_ctx_t;

  typedef struct packed {
    ray_t        ray;
    logic [63:0] a;
    logic        live;
    logic        pos1;
    logic        pos2;
    logic        sat1;
    logic        sat2;
  } dv_ctx_t;

  typedef struct packed {
    logic               hit;
    logic        [31:0] t;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [16:0] z;
  } cd_ctx_t;

  function automatic logic [TURN_W-1:0] turn_angle(input logic [4:0] idx);
    logic [TURN_W-1:0] r;
    case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2F9;
      5'd15:   r = 32'h0000_517C;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A2F;
      5'd19:   r = 32'h0000_0517;
      5'd20:   r = 32'h0000_028B;
      5'd21:   r = 32'h0000_0145;
      5'd22:   r = 32'h0000_00A2;
      5'd23:   r = 32'h0000_0051;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v[65:31] != {35{v[65]}}) begin
      r = v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/rch_setup.sv
// ----------------------------------------------------------------------------
// rch_setup
// Quadratic coefficients and quarter discriminant over five register stages.
// ----------------------------------------------------------------------------
module rch_setup import rch_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int DW = 64 + 2 * FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  ray_t          in_ray,
  output logic          out_vld,
  output sq_ctx_t       out_ctx,
  output logic [DW-1:0] out_d
);

  localparam logic [63:0] PAR_LIMIT =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd999999999999) / 64'd1000000000000;

  logic               v1, v2, v3, v4;
  ray_t               ray1, ray2, ray3, ray4;
  logic signed [63:0] pxx, pyy, pbx, pby, pcx, pcy;
  logic        [63:0] a2, a3, a4;
  logic signed [64:0] b2, b3, b4;
  logic        [63:0] crm2;
  logic               par2, par3, par4;
  logic        [63:0] p00, p01, p11;
  logic       [127:0] sq4;

  logic        [63:0] a_next;
  logic signed [64:0] b_next;
  logic signed [64:0] cr_next;
  logic       [127:0] diff;

  always_comb begin
    a_next  = pxx + pyy;
    b_next  = {pbx[63], pbx} + {pby[63], pby};
    cr_next = {pcx[63], pcx} - {pcy[63], pcy};
    diff    = ({64'd0, a4} << (2 * FRAC_BITS)) - sq4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      v4      <= v3;
      out_vld <= v4;
    end
    if (adv) begin
      ray1 <= in_ray;
      pxx  <= $signed(in_ray.dx) * $signed(in_ray.dx);
      pyy  <= $signed(in_ray.dy) * $signed(in_ray.dy);
      pbx  <= $signed(in_ray.ox) * $signed(in_ray.dx);
      pby  <= $signed(in_ray.oy) * $signed(in_ray.dy);
      pcx  <= $signed(in_ray.ox) * $signed(in_ray.dy);
      pcy  <= $signed(in_ray.oy) * $signed(in_ray.dx);

      ray2 <= ray1;
      a2   <= a_next;
      b2   <= b_next;
      crm2 <= cr_next[64] ? 64'(-cr_next) : cr_next[63:0];
      par2 <= a_next < PAR_LIMIT;

      ray3 <= ray2;
      a3   <= a2;
      b3   <= b2;
      par3 <= par2;
      p00  <= crm2[31:0] * crm2[31:0];
      p01  <= crm2[31:0] * crm2[63:32];
      p11  <= crm2[63:32] * crm2[63:32];

      ray4 <= ray3;
      a4   <= a3;
      b4   <= b3;
      par4 <= par3;
      sq4  <= {p11, 64'd0} + {31'd0, p01, 33'd0} + {64'd0, p00};

      out_ctx.ray  <= ray4;
      out_ctx.a    <= a4;
      out_ctx.b    <= b4;
      out_ctx.live <= !par4 && !diff[127];
      out_d        <= diff[DW-1:0];
    end
  end

endmodule

FILE: src/rch_sqrt.sv
// ----------------------------------------------------------------------------
// rch_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rch_sqrt import rch_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int SW = 32 + FRAC_BITS,
  localparam int DW = 2 * SW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  sq_ctx_t       in_ctx,
  input  logic [DW-1:0] in_d,
  output logic          out_vld,
  output sq_ctx_t       out_ctx,
  output logic [SW-1:0] out_root
);

  logic          vld  [SW];
  logic [SW+1:0] rem  [SW];
  logic [SW-1:0] root [SW];
  logic [DW-1:0] dsh  [SW];
  sq_ctx_t       ctx  [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic          v_p;
    logic [SW+1:0] rem_p;
    logic [SW-1:0] root_p;
    logic [DW-1:0] d_p;
    sq_ctx_t       c_p;
    logic [SW+1:0] rem_cat;
    logic [SW+1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_p    = in_vld;
      assign rem_p  = '0;
      assign root_p = '0;
      assign d_p    = in_d;
      assign c_p    = in_ctx;
    end else begin : g_next
      assign v_p    = vld[k-1];
      assign rem_p  = rem[k-1];
      assign root_p = root[k-1];
      assign d_p    = dsh[k-1];
      assign c_p    = ctx[k-1];
    end

    assign rem_cat = {rem_p[SW-1:0], d_p[DW-1:DW-2]};
    assign trial   = {root_p, 2'b01};
    assign ge      = rem_cat >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= v_p;
      end
      if (adv) begin
        rem[k]  <= ge ? rem_cat - trial : rem_cat;
        root[k] <= {root_p[SW-2:0], ge};
        dsh[k]  <= d_p << 2;
        ctx[k]  <= c_p;
      end
    end
  end

  assign out_vld  = vld[SW-1];
  assign out_ctx  = ctx[SW-1];
  assign out_root = root[SW-1];

endmodule

FILE: src/rch_div.sv
// ----------------------------------------------------------------------------
// rch_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rch_div import rch_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_vld,
  input  dv_ctx_t     in_ctx,
  input  logic [63:0] in_r1,
  input  logic [63:0] in_r2,
  input  logic [31:0] in_m1,
  input  logic [31:0] in_m2,
  output logic        out_vld,
  output dv_ctx_t     out_ctx,
  output logic [31:0] out_q1,
  output logic [31:0] out_q2
);

  localparam int QB = 32;

  logic        vld [QB];
  dv_ctx_t     ctx [QB];
  logic [63:0] rr  [QB][2];
  logic [31:0] mm  [QB][2];
  logic [31:0] qq  [QB][2];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic    v_p;
    dv_ctx_t c_p;

    if (k == 0) begin : g_first
      assign v_p = in_vld;
      assign c_p = in_ctx;
    end else begin : g_next
      assign v_p = vld[k-1];
      assign c_p = ctx[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= v_p;
      end
      if (adv) begin
        ctx[k] <= c_p;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [63:0] r_p;
      logic [31:0] m_p;
      logic [31:0] q_p;
      logic [64:0] r_cat;
      logic        ge;

      if (k == 0) begin : g_first
        assign r_p = (l == 0) ? in_r1 : in_r2;
        assign m_p = (l == 0) ? in_m1 : in_m2;
        assign q_p = '0;
      end else begin : g_next
        assign r_p = rr[k-1][l];
        assign m_p = mm[k-1][l];
        assign q_p = qq[k-1][l];
      end

      assign r_cat = {r_p, m_p[31]};
      assign ge    = r_cat >= {1'b0, c_p.a};

      always_ff @(posedge clk) begin
        if (adv) begin
          rr[k][l] <= ge ? 64'(r_cat - {1'b0, c_p.a}) : r_cat[63:0];
          mm[k][l] <= m_p << 1;
          qq[k][l] <= {q_p[30:0], ge};
        end
      end
    end
  end

  assign out_vld = vld[QB-1];
  assign out_ctx = ctx[QB-1];
  assign out_q1  = qq[QB-1][0];
  assign out_q2  = qq[QB-1][1];

endmodule

FILE: src/rch_cordic.sv
// ----------------------------------------------------------------------------
// rch_cordic
// Pipelined vectoring CORDIC giving the azimuth of the hit point in turns.
// ----------------------------------------------------------------------------
module rch_cordic import rch_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_vld,
  input  cd_ctx_t           in_ctx,
  output logic              out_vld,
  output cd_ctx_t           out_ctx,
  output logic [TURN_W-1:0] out_ang,
  output logic              out_zero
);

  logic                   pv;
  cd_ctx_t                pc;
  logic signed [CW-1:0]   px, py;
  logic [TURN_W-1:0]      pa;
  logic                   pz;
  logic signed [CW-1:0]   xs, ys;

  assign xs = {{(CW-56){in_ctx.x[31]}}, in_ctx.x, 24'd0};
  assign ys = {{(CW-56){in_ctx.y[31]}}, in_ctx.y, 24'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (adv) begin
      pv <= in_vld;
    end
    if (adv) begin
      pc <= in_ctx;
      pz <= (in_ctx.x == '0) && (in_ctx.y == '0);
      if (in_ctx.x[31]) begin
        px <= -xs;
        py <= -ys;
        pa <= 32'h8000_0000;
      end else begin
        px <= xs;
        py <= ys;
        pa <= '0;
      end
    end
  end

  logic                 sv [CORDIC_STEPS];
  cd_ctx_t              sc [CORDIC_STEPS];
  logic signed [CW-1:0] sx [CORDIC_STEPS];
  logic signed [CW-1:0] sy [CORDIC_STEPS];
  logic [TURN_W-1:0]    sa [CORDIC_STEPS];
  logic                 sz [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
    logic                 v_p;
    cd_ctx_t              c_p;
    logic signed [CW-1:0] x_p, y_p, xsh, ysh;
    logic [TURN_W-1:0]    a_p, step;
    logic                 z_p;

    if (k == 0) begin : g_first
      assign v_p = pv;
      assign c_p = pc;
      assign x_p = px;
      assign y_p = py;
      assign a_p = pa;
      assign z_p = pz;
    end else begin : g_next
      assign v_p = sv[k-1];
      assign c_p = sc[k-1];
      assign x_p = sx[k-1];
      assign y_p = sy[k-1];
      assign a_p = sa[k-1];
      assign z_p = sz[k-1];
    end

    assign xsh  = x_p >>> k;
    assign ysh  = y_p >>> k;
    assign step = turn_angle(5'(k));

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (adv) begin
        sv[k] <= v_p;
      end
      if (adv) begin
        sc[k] <= c_p;
        sz[k] <= z_p;
        if (!y_p[CW-1]) begin
          sx[k] <= x_p + ysh;
          sy[k] <= y_p - xsh;
          sa[k] <= a_p + step;
        end else begin
          sx[k] <= x_p - ysh;
          sy[k] <= y_p + xsh;
          sa[k] <= a_p - step;
        end
      end
    end
  end

  assign out_vld  = sv[CORDIC_STEPS-1];
  assign out_ctx  = sc[CORDIC_STEPS-1];
  assign out_ang  = sa[CORDIC_STEPS-1];
  assign out_zero = sz[CORDIC_STEPS-1];

endmodule

FILE: src/ray_unit_cylinder_hit.sv
// Throughput: one ray per cycle while no waiting result holds the stages.
// The square root and divider stages set the depth.
// A waiting result holds every stage; in_ready follows out_ready through that hold.
// Reset clears the valid bit of every stage; data registers are not reset.
// ----------------------------------------------------------------------------
// ray_unit_cylinder_hit
// Ray against the unit cylinder x*x + y*y = 1, 0 <= z <= 1, fixed point.
// ----------------------------------------------------------------------------
module ray_unit_cylinder_hit import rch_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic        [31:0] t_limit,
  input  logic               have_prior,
  input  logic        [31:0] prior_t,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic        [31:0] hit_t,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic        [16:0] point_z,
  output logic        [15:0] coord_u
);

  localparam int SW = 32 + FRAC_BITS;
  localparam int DW = 2 * SW;
  localparam int NW = 66;
  localparam int SH = 32 - FRAC_BITS;

  logic adv;
  ray_t in_ray;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign in_ray.ox = origin_x;
  assign in_ray.oy = origin_y;
  assign in_ray.oz = origin_z;
  assign in_ray.dx = dir_x;
  assign in_ray.dy = dir_y;
  assign in_ray.dz = dir_z;
  assign in_ray.tl = t_limit;
  assign in_ray.hp = have_prior;
  assign in_ray.pt = prior_t;

  logic          su_vld;
  sq_ctx_t       su_ctx;
  logic [DW-1:0] su_d;

  rch_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (in_valid),
    .in_ray  (in_ray),
    .out_vld (su_vld),
    .out_ctx (su_ctx),
    .out_d   (su_d)
  );

  logic          sq_vld;
  sq_ctx_t       sq_ctx;
  logic [SW-1:0] sq_root;

  rch_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (su_vld),
    .in_ctx   (su_ctx),
    .in_d     (su_d),
    .out_vld  (sq_vld),
    .out_ctx  (sq_ctx),
    .out_root (sq_root)
  );

  // root numerators: -b/2 minus and plus the root of the quarter discriminant
  logic                 n_vld;
  ray_t                 n_ray;
  logic [63:0]          n_a;
  logic                 n_live;
  logic signed [NW-1:0] n1, n2;
  logic signed [NW-1:0] nb, sq_ext;

  assign nb     = -{sq_ctx.b[64], sq_ctx.b};
  assign sq_ext = {{(NW-SW){1'b0}}, sq_root};

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (adv) begin
      n_vld <= sq_vld;
    end
    if (adv) begin
      n_ray  <= sq_ctx.ray;
      n_a    <= sq_ctx.a;
      n_live <= sq_ctx.live;
      n1     <= nb - sq_ext;
      n2     <= nb + sq_ext;
    end
  end

  logic          dv_in_vld;
  dv_ctx_t       dv_in_ctx;
  logic [63:0]   dv_r1, dv_r2;
  logic [31:0]   dv_m1, dv_m2;
  logic [NW-1:0] hi1, hi2;
  logic [NW-1:0] a_ext;

  assign hi1   = n1 >> SH;
  assign hi2   = n2 >> SH;
  assign a_ext = {{(NW-64){1'b0}}, n_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_in_vld <= 1'b0;
    end else if (adv) begin
      dv_in_vld <= n_vld;
    end
    if (adv) begin
      dv_in_ctx.ray  <= n_ray;
      dv_in_ctx.a    <= n_a;
      dv_in_ctx.live <= n_live;
      dv_in_ctx.pos1 <= !n1[NW-1] && (n1 != '0);
      dv_in_ctx.pos2 <= !n2[NW-1] && (n2 != '0);
      dv_in_ctx.sat1 <= hi1 >= a_ext;
      dv_in_ctx.sat2 <= hi2 >= a_ext;
      dv_r1          <= hi1[63:0];
      dv_r2          <= hi2[63:0];
      dv_m1          <= {n1[SH-1:0], {FRAC_BITS{1'b0}}};
      dv_m2          <= {n2[SH-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  logic        dv_vld;
  dv_ctx_t     dv_ctx;
  logic [31:0] dv_q1, dv_q2;

  rch_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (dv_in_vld),
    .in_ctx  (dv_in_ctx),
    .in_r1   (dv_r1),
    .in_r2   (dv_r2),
    .in_m1   (dv_m1),
    .in_m2   (dv_m2),
    .out_vld (dv_vld),
    .out_ctx (dv_ctx),
    .out_q1  (dv_q1),
    .out_q2  (dv_q2)
  );

  // saturate t, check range, form direction products for both roots
  logic [31:0]        t1_next, t2_next;
  logic               p_vld;
  ray_t               p_ray;
  logic [31:0]        p_t1, p_t2;
  logic               p_ok1, p_ok2;
  logic signed [64:0] pz1, pz2, px1, px2, py1, py2;

  assign t1_next = dv_ctx.sat1 ? 32'hFFFF_FFFF : dv_q1;
  assign t2_next = dv_ctx.sat2 ? 32'hFFFF_FFFF : dv_q2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (adv) begin
      p_vld <= dv_vld;
    end
    if (adv) begin
      p_ray <= dv_ctx.ray;
      p_t1  <= t1_next;
      p_t2  <= t2_next;
      p_ok1 <= dv_ctx.live && dv_ctx.pos1 && (t1_next != '0) &&
               (t1_next <= dv_ctx.ray.tl) && !(dv_ctx.ray.hp && (dv_ctx.ray.pt < t1_next));
      p_ok2 <= dv_ctx.live && dv_ctx.pos2 && (t2_next != '0) &&
               (t2_next <= dv_ctx.ray.tl) && !(dv_ctx.ray.hp && (dv_ctx.ray.pt < t2_next));
      pz1   <= $signed({1'b0, t1_next}) * $signed(dv_ctx.ray.dz);
      pz2   <= $signed({1'b0, t2_next}) * $signed(dv_ctx.ray.dz);
      px1   <= $signed({1'b0, t1_next}) * $signed(dv_ctx.ray.dx);
      px2   <= $signed({1'b0, t2_next}) * $signed(dv_ctx.ray.dx);
      py1   <= $signed({1'b0, t1_next}) * $signed(dv_ctx.ray.dy);
      py2   <= $signed({1'b0, t2_next}) * $signed(dv_ctx.ray.dy);
    end
  end

  // hit point of each root, z test, nearer accepted root wins
  logic signed [64:0] pzs1, pzs2, pxs1, pxs2, pys1, pys2;
  logic signed [65:0] z1, z2, x1, x2, y1, y2;
  logic               zok1, zok2, sel1, sel2;
  logic               c_vld;
  cd_ctx_t            c_ctx;
  cd_ctx_t            c_next;

  always_comb begin
    pzs1   = pz1 >>> FRAC_BITS;
    pzs2   = pz2 >>> FRAC_BITS;
    pxs1   = px1 >>> FRAC_BITS;
    pxs2   = px2 >>> FRAC_BITS;
    pys1   = py1 >>> FRAC_BITS;
    pys2   = py2 >>> FRAC_BITS;
    z1     = {{34{p_ray.oz[31]}}, p_ray.oz} + {pzs1[64], pzs1};
    z2     = {{34{p_ray.oz[31]}}, p_ray.oz} + {pzs2[64], pzs2};
    x1     = {{34{p_ray.ox[31]}}, p_ray.ox} + {pxs1[64], pxs1};
    x2     = {{34{p_ray.ox[31]}}, p_ray.ox} + {pxs2[64], pxs2};
    y1     = {{34{p_ray.oy[31]}}, p_ray.oy} + {pys1[64], pys1};
    y2     = {{34{p_ray.oy[31]}}, p_ray.oy} + {pys2[64], pys2};
    zok1   = !z1[65] && (z1[64:0] <= (65'd1 << FRAC_BITS));
    zok2   = !z2[65] && (z2[64:0] <= (65'd1 << FRAC_BITS));
    sel1   = p_ok1 && zok1;
    sel2   = p_ok2 && zok2;
    c_next = '0;
    if (sel1) begin
      c_next.hit = 1'b1;
      c_next.t   = p_t1;
      c_next.x   = sat32(x1);
      c_next.y   = sat32(y1);
      c_next.z   = z1[16:0];
    end else if (sel2) begin
      c_next.hit = 1'b1;
      c_next.t   = p_t2;
      c_next.x   = sat32(x2);
      c_next.y   = sat32(y2);
      c_next.z   = z2[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= p_vld;
    end
    if (adv) begin
      c_ctx <= c_next;
    end
  end

  logic              cd_vld;
  cd_ctx_t           cd_ctx;
  logic [TURN_W-1:0] cd_ang;
  logic              cd_zero;
  logic [TURN_W-1:0] ang_rnd;

  rch_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (c_vld),
    .in_ctx   (c_ctx),
    .out_vld  (cd_vld),
    .out_ctx  (cd_ctx),
    .out_ang  (cd_ang),
    .out_zero (cd_zero)
  );

  assign ang_rnd = cd_ang + 32'h0000_8000;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cd_vld;
    end
    if (adv) begin
      hit     <= cd_ctx.hit;
      hit_t   <= cd_ctx.t;
      point_x <= cd_ctx.x;
      point_y <= cd_ctx.y;
      point_z <= cd_ctx.z;
      coord_u <= (cd_ctx.hit && !cd_zero) ? ang_rnd[31:16] : '0;
    end
  end

endmodule
